### hw/rtl/staging_slot_suballocator_core_macros.svh
// Assertion macros for the staging slot suballocator checker.
// Included by the checker file only; no other dependencies.
`ifndef STAGING_SLOT_SUBALLOCATOR_CORE_MACROS_SVH
`define STAGING_SLOT_SUBALLOCATOR_CORE_MACROS_SVH

// The condition must never hold outside reset.
`define STSA_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define STSA_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define STSA_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/stsa_pkg.sv
// Shared types and constants of the staging slot suballocator.
// No dependencies; used by the slot store, the top level and the checker.
package stsa_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 8;
  localparam int unsigned SLOT_IDX_W     = 4;   // enough for the largest slot count
  localparam int unsigned CAP_W          = 32;
  localparam int unsigned FILL_W         = 33;
  localparam int unsigned FENCE_W        = 64;
  localparam int unsigned USAGE_W        = 36;
  localparam int unsigned SIZE_W         = 32;
  localparam int unsigned ALIGN_W        = 5;
  localparam int unsigned COUNT_W        = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 32'd67108864;

  typedef enum logic [1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_MARK    = 2'd1,
    KIND_RECLAIM = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAST_EVAL,
    ST_SCAN_READ,
    ST_SCAN_EVAL,
    ST_FIRST_IDLE,
    ST_FIT,
    ST_MARK,
    ST_RECL_READ,
    ST_RECL_EVAL,
    ST_DONE
  } state_t;

  // Access request from the sequencer to the slot store.
  typedef struct packed {
    logic [SLOT_IDX_W-1:0] rd_addr;
    logic [SLOT_IDX_W-1:0] wr_addr;
    logic                  fill_we;
    logic                  fill_clr;
    logic [FILL_W-1:0]     fill_data;
    logic                  fence_we;
    logic                  fence_clr;
    logic [FENCE_W-1:0]    fence_data;
  } store_req_t;

endpackage

### hw/rtl/stsa_slot_store.sv
// Slot store: fill and fence memories with registered reads.
// Depends on stsa_pkg; entries that are not valid read as zero.
module stsa_slot_store #(
  parameter int unsigned SLOT_COUNT = stsa_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  stsa_pkg::store_req_t              req,
  output logic [stsa_pkg::FILL_W-1:0]       rd_fill,
  output logic [stsa_pkg::FENCE_W-1:0]      rd_fence
);
  import stsa_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [FILL_W-1:0]  fill_mem  [SLOT_COUNT];
  logic [FENCE_W-1:0] fence_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] fill_vld;
  logic [SLOT_COUNT-1:0] fence_vld;
  logic [FILL_W-1:0]  fill_q;
  logic [FENCE_W-1:0] fence_q;
  logic               fill_q_vld;
  logic               fence_q_vld;
  logic [IW-1:0]      ra;
  logic [IW-1:0]      wa;

  assign ra = req.rd_addr[IW-1:0];
  assign wa = req.wr_addr[IW-1:0];

  always_ff @(posedge clk) begin
    if (req.fill_we) begin
      fill_mem[wa] <= req.fill_data;
    end
    if (req.fence_we) begin
      fence_mem[wa] <= req.fence_data;
    end
    fill_q  <= fill_mem[ra];
    fence_q <= fence_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_vld    <= '0;
      fence_vld   <= '0;
      fill_q_vld  <= 1'b0;
      fence_q_vld <= 1'b0;
    end else begin
      if (req.fill_we) begin
        fill_vld[wa] <= 1'b1;
      end else if (req.fill_clr) begin
        fill_vld[wa] <= 1'b0;
      end
      if (req.fence_we) begin
        fence_vld[wa] <= 1'b1;
      end else if (req.fence_clr) begin
        fence_vld[wa] <= 1'b0;
      end
      fill_q_vld  <= fill_vld[ra];
      fence_q_vld <= fence_vld[ra];
    end
  end

  assign rd_fill  = fill_q_vld ? fill_q : '0;
  assign rd_fence = fence_q_vld ? fence_q : '0;

endmodule

### hw/rtl/staging_slot_suballocator_core.sv
// Staging slot suballocator; depends on stsa_pkg and stsa_slot_store. Requests are
// worked one at a time and a new one is taken the cycle after the previous result is
// loaded. Reclaim walks every slot, and acquire tries the last granted slot and then
// scans the slots, each with a read state and an evaluate state per entry through the
// slot store's single read port.
// Synchronous active-high reset clears statistics, busy marks and store valid bits and reloads the reset capacity.
module staging_slot_suballocator_core #(
  parameter int unsigned SLOT_COUNT = stsa_pkg::SLOT_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // request_size[31:0], align_log2[36:32],
                                  // target_slot[40:37], fence_value[104:41], zero pad
  input  logic [1:0]   s_tuser,   // kind[1:0]
  // Result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata,   // granted_slot[2:0], granted_offset[34:3],
                                  // busy_slots[38:35], idle_slots[42:39],
                                  // usage_now[78:43], usage_peak[114:79],
                                  // oversized_total[146:115], zero pad
  output logic [1:0]   m_tuser,   // granted[0], oversized[1]
  // Capacity register write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);
  import stsa_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  state_t state, state_next;

  // Latched request
  logic [SIZE_W-1:0]    size;
  logic [ALIGN_W-1:0]   alog;
  logic [SLOT_IDX_W-1:0] target;
  logic [FENCE_W-1:0]   fence;

  // Allocator state held in flops
  logic [CAP_W-1:0]      cap;
  logic [SLOT_COUNT-1:0] busy;
  logic [CW-1:0]         busy_cnt;
  logic [IW-1:0]         last_slot;
  logic [USAGE_W-1:0]    in_use;
  logic [USAGE_W-1:0]    peak;
  logic [COUNT_W-1:0]    fallbacks;

  // Working registers of the sequencer
  logic [IW-1:0]      idx;
  logic [IW-1:0]      chosen;
  logic [FILL_W-1:0]  chosen_fill;
  logic               res_granted;
  logic               res_over;
  logic [2:0]         res_slot;
  logic [SIZE_W-1:0]  res_off;

  store_req_t         sreq;
  logic [FILL_W-1:0]  rd_fill;
  logic [FENCE_W-1:0] rd_fence;

  stsa_slot_store #(.SLOT_COUNT(SLOT_COUNT)) u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (sreq),
    .rd_fill  (rd_fill),
    .rd_fence (rd_fence)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  logic accept;
  assign accept = s_tvalid && s_tready;

  // An acquire larger than the capacity is oversized straight away.
  logic early_over;
  assign early_over = accept && (s_tuser == KIND_ACQUIRE) && (s_tdata[31:0] > cap);

  // A slot has room when it is not in flight and its fill plus the request fits.
  logic [FILL_W:0] room_sum;
  logic            room_ok;
  logic            cur_busy;
  assign cur_busy = (state == ST_LAST_EVAL) ? busy[last_slot] : busy[idx];
  assign room_sum = {1'b0, rd_fill} + (FILL_W+1)'(size);
  assign room_ok  = !cur_busy && (room_sum <= (FILL_W+1)'(cap));

  // First slot not in flight, for the fallback that restarts a slot at zero.
  logic          idle_found;
  logic [IW-1:0] idle_idx;
  always_comb begin
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!idle_found && !busy[i]) begin
        idle_found = 1'b1;
        idle_idx   = IW'(i);
      end
    end
  end

  // Alignment of the chosen fill and the resulting end of the region.
  logic [FILL_W:0]   align_mask;
  logic [FILL_W:0]   aligned;
  logic [FILL_W+1:0] region_end;
  logic              fit_ok;
  assign align_mask = ((FILL_W+1)'(1) << alog) - (FILL_W+1)'(1);
  assign aligned    = ({1'b0, chosen_fill} + align_mask) & ~align_mask;
  assign region_end = {1'b0, aligned} + (FILL_W+2)'(size);
  assign fit_ok     = region_end <= (FILL_W+2)'(cap);

  // Usage arithmetic with saturation at both ends.
  logic [USAGE_W:0]   use_sum;
  logic [USAGE_W-1:0] use_add;
  logic [USAGE_W-1:0] use_sub;
  assign use_sum = {1'b0, in_use} + (USAGE_W+1)'(size);
  assign use_add = use_sum[USAGE_W] ? '1 : use_sum[USAGE_W-1:0];
  assign use_sub = (in_use > USAGE_W'(cap)) ? (in_use - USAGE_W'(cap)) : '0;

  logic recl_hit;
  assign recl_hit = busy[idx] && (rd_fence <= fence);

  logic mark_ok;
  assign mark_ok = ({1'b0, target} < (SLOT_IDX_W+1)'(SLOT_COUNT));

  // Next state and store requests.
  always_comb begin
    state_next      = state;
    sreq            = '0;
    sreq.rd_addr    = SLOT_IDX_W'(idx);
    sreq.wr_addr    = SLOT_IDX_W'(idx);
    unique case (state)
      ST_IDLE: begin
        // Read the last granted slot ahead of a possible acquire.
        sreq.rd_addr = SLOT_IDX_W'(last_slot);
        if (accept) begin
          unique case (s_tuser)
            KIND_ACQUIRE: begin
              if (s_tdata[31:0] > cap) begin
                state_next = ST_DONE;
              end else begin
                state_next = ST_LAST_EVAL;
              end
            end
            KIND_MARK:    state_next = ST_MARK;
            KIND_RECLAIM: state_next = ST_RECL_READ;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_LAST_EVAL: begin
        state_next = room_ok ? ST_FIT : ST_SCAN_READ;
      end
      ST_SCAN_READ: begin
        state_next = ST_SCAN_EVAL;
      end
      ST_SCAN_EVAL: begin
        if (room_ok) begin
          state_next = ST_FIT;
        end else if (idx == LAST_IDX) begin
          state_next = ST_FIRST_IDLE;
        end else begin
          state_next = ST_SCAN_READ;
        end
      end
      ST_FIRST_IDLE: begin
        sreq.wr_addr  = SLOT_IDX_W'(idle_idx);
        sreq.fill_clr = idle_found;
        state_next    = idle_found ? ST_FIT : ST_DONE;
      end
      ST_FIT: begin
        sreq.wr_addr   = SLOT_IDX_W'(chosen);
        sreq.fill_we   = fit_ok;
        sreq.fill_data = region_end[FILL_W-1:0];
        state_next     = ST_DONE;
      end
      ST_MARK: begin
        sreq.wr_addr    = target;
        sreq.fence_we   = mark_ok;
        sreq.fence_data = fence;
        state_next      = ST_DONE;
      end
      ST_RECL_READ: begin
        state_next = ST_RECL_EVAL;
      end
      ST_RECL_EVAL: begin
        sreq.fill_clr  = recl_hit;
        sreq.fence_clr = recl_hit;
        state_next     = (idx == LAST_IDX) ? ST_DONE : ST_RECL_READ;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request fields on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      size   <= s_tdata[31:0];
      alog   <= s_tdata[36:32];
      target <= s_tdata[40:37];
      fence  <= s_tdata[104:41];
    end
  end

  // Allocator state and sequencer working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap         <= CAP_RESET;
      busy        <= '0;
      busy_cnt    <= '0;
      last_slot   <= '0;
      in_use      <= '0;
      peak        <= '0;
      fallbacks   <= '0;
      res_granted <= 1'b0;
      res_over    <= 1'b0;
      idx         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          idx         <= '0;
          res_granted <= 1'b0;
          res_over    <= early_over;
          res_slot    <= '0;
          res_off     <= '0;
          if (early_over && (fallbacks != '1)) begin
            fallbacks <= fallbacks + COUNT_W'(1);
          end
        end
        ST_LAST_EVAL: begin
          chosen      <= last_slot;
          chosen_fill <= rd_fill;
        end
        ST_SCAN_READ: begin
        end
        ST_SCAN_EVAL: begin
          chosen      <= idx;
          chosen_fill <= rd_fill;
          if (!room_ok && (idx != LAST_IDX)) begin
            idx <= idx + IW'(1);
          end
        end
        ST_FIRST_IDLE: begin
          chosen      <= idle_idx;
          chosen_fill <= '0;
          if (!idle_found) begin
            res_over <= 1'b1;
            if (fallbacks != '1) begin
              fallbacks <= fallbacks + COUNT_W'(1);
            end
          end
        end
        ST_FIT: begin
          if (fit_ok) begin
            res_granted <= 1'b1;
            res_slot    <= 3'(chosen);
            res_off     <= aligned[SIZE_W-1:0];
            last_slot   <= chosen;
            in_use      <= use_add;
            if (use_add > peak) begin
              peak <= use_add;
            end
          end else begin
            res_over <= 1'b1;
            if (fallbacks != '1) begin
              fallbacks <= fallbacks + COUNT_W'(1);
            end
          end
        end
        ST_MARK: begin
          if (mark_ok) begin
            busy[target[IW-1:0]] <= 1'b1;
            if (!busy[target[IW-1:0]]) begin
              busy_cnt <= busy_cnt + CW'(1);
            end
          end
        end
        ST_RECL_READ: begin
        end
        ST_RECL_EVAL: begin
          if (recl_hit) begin
            busy[idx] <= 1'b0;
            busy_cnt  <= busy_cnt - CW'(1);
            in_use    <= use_sub;
          end
          if (idx != LAST_IDX) begin
            idx <= idx + IW'(1);
          end
        end
        ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: loaded as the sequencer leaves its done state.
  logic load_out;
  assign load_out = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= {res_over, res_granted};
      m_tdata <= {5'b0, fallbacks, peak, in_use,
                  4'(CW'(SLOT_COUNT) - busy_cnt), 4'(busy_cnt), res_off, res_slot};
    end
  end

endmodule

### hw/rtl/stsa_checker.sv
// Port-level checker for the staging slot suballocator, bound to the top level.
// Depends on stsa_pkg and the assertion macros header.
`include "staging_slot_suballocator_core_macros.svh"

module stsa_checker #(
  parameter int unsigned SLOT_COUNT = stsa_pkg::SLOT_COUNT_DEF
) (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [151:0] m_tdata,
  input logic [1:0]   m_tuser
);
  import stsa_pkg::*;

  `STSA_NEVER(a_grant_excl, clk, rst, m_tvalid && m_tuser[0] && m_tuser[1], "granted and oversized together")
  `STSA_SAME(a_slot_sum, clk, rst, m_tvalid, (m_tdata[38:35] + m_tdata[42:39]) == 4'(SLOT_COUNT), "busy plus idle differs from slot count")
  `STSA_SAME(a_peak, clk, rst, m_tvalid, m_tdata[114:79] >= m_tdata[78:43], "peak usage below current usage")
  `STSA_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "request taken while another is in work")
  `STSA_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind staging_slot_suballocator_core stsa_checker #(.SLOT_COUNT(SLOT_COUNT)) u_stsa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
